FILE: hw/rtl/pzhd_pkg.sv
// Shared types and constants of the piezo hit detector.
`default_nettype none
package pzhd_pkg;

   localparam int CHAN_W     = 2;
   localparam int SAMPLE_W   = 10;
   localparam int TIME_W     = 32;
   localparam int LOCKOUT_W  = 16;
   localparam int BASE_W     = 7;
   localparam int NOTE_W     = 8;
   localparam int VEL_W      = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // (sample - threshold) * 126 fits 17 bits; divisor is the 10-bit span
   localparam int DIVIDEND_W = 17;
   localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);
   localparam int STEP_CNT_W = $clog2(TIME_W);

   localparam logic [SAMPLE_W-1:0]   ADC_FULL   = 10'd1023;
   localparam logic [DIVIDEND_W-1:0] VEL_TOP_Q  = 17'd126;
   localparam logic [VEL_W-1:0]      VEL_MAX    = 7'd127;

   localparam logic [SAMPLE_W-1:0]  THRESHOLD_RST = 10'd50;
   localparam logic [LOCKOUT_W-1:0] LOCKOUT_RST   = 16'd50;
   localparam logic [BASE_W-1:0]    BASE_NOTE_RST = 7'd36;

   localparam logic [CSR_IDX_W-1:0] CSR_IDX_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_LOCKOUT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_BASE_NOTE = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FINISH
   } pzhd_state_type;

   // control from the sequencer to the serial units
   typedef struct packed {
      logic load;
      logic step;
   } pzhd_ser_ctl_type;

endpackage
`default_nettype wire

FILE: hw/rtl/pzhd_if.sv
// Valid/ready channel interfaces: sample input, hit result and register writes.
`default_nettype none
interface pzhd_req_if import pzhd_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CHAN_W-1:0]   channel;
   logic [SAMPLE_W-1:0] sample;
   logic [TIME_W-1:0]   now_ms;

   modport source (output valid, channel, sample, now_ms, input ready);
   modport sink   (input valid, channel, sample, now_ms, output ready);
endinterface

interface pzhd_rsp_if import pzhd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              hit;
   logic [NOTE_W-1:0] note;
   logic [VEL_W-1:0]  velocity;

   modport source (output valid, hit, note, velocity, input ready);
   modport sink   (input valid, hit, note, velocity, output ready);
endinterface

interface pzhd_csr_if import pzhd_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/pzhd_lockout_cmp.sv
// Bit-serial elapsed-time subtract and compare against the lockout window.
`default_nettype none
module pzhd_lockout_cmp
   import pzhd_pkg::*;
(
   input  wire logic                 clock,
   input  wire pzhd_ser_ctl_type     ctl,
   input  wire logic [TIME_W-1:0]    now_ms,
   input  wire logic [TIME_W-1:0]    last_ms,
   input  wire logic [LOCKOUT_W-1:0] lockout_ms,
   output logic                      expired
);

   logic [TIME_W-1:0]    now_ff,  now_in;
   logic [TIME_W-1:0]    last_ff, last_in;
   logic [LOCKOUT_W-1:0] lock_ff, lock_in;
   logic                 borrow_ff, borrow_in;
   logic                 gt_ff, gt_in;
   logic                 diff_bit;

   // LSB first: the last differing bit decides which word is greater
   always_comb begin
      now_in    = now_ff;
      last_in   = last_ff;
      lock_in   = lock_ff;
      borrow_in = borrow_ff;
      gt_in     = gt_ff;
      diff_bit  = now_ff[0] ^ last_ff[0] ^ borrow_ff;
      if (ctl.load) begin
         now_in    = now_ms;
         last_in   = last_ms;
         lock_in   = lockout_ms;
         borrow_in = 1'b0;
         gt_in     = 1'b0;
      end else if (ctl.step) begin
         borrow_in = (~now_ff[0] & last_ff[0]) | (~(now_ff[0] ^ last_ff[0]) & borrow_ff);
         if (diff_bit != lock_ff[0]) begin
            gt_in = diff_bit;
         end
         now_in  = {1'b0, now_ff[TIME_W-1:1]};
         last_in = {1'b0, last_ff[TIME_W-1:1]};
         lock_in = {1'b0, lock_ff[LOCKOUT_W-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      now_ff    <= now_in;
      last_ff   <= last_in;
      lock_ff   <= lock_in;
      borrow_ff <= borrow_in;
      gt_ff     <= gt_in;
   end

   assign expired = gt_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/pzhd_vel_div.sv
// Restoring divider, one quotient bit per cycle while ctl.step is high, for the velocity scaling.
`default_nettype none
module pzhd_vel_div
   import pzhd_pkg::*;
(
   input  wire logic                  clock,
   input  wire pzhd_ser_ctl_type      ctl,
   input  wire logic [DIVIDEND_W-1:0] dividend,
   input  wire logic [SAMPLE_W-1:0]   divisor,
   output logic [DIVIDEND_W-1:0]      quotient
);

   logic [DIVIDEND_W-1:0] num_ff, num_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [SAMPLE_W-1:0]   rem_ff, rem_in;
   logic [SAMPLE_W-1:0]   div_ff, div_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [SAMPLE_W:0]     trial;
   logic [SAMPLE_W:0]     trial_sub;

   always_comb begin
      num_in    = num_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      div_in    = div_ff;
      cnt_in    = cnt_ff;
      trial     = {rem_ff, num_ff[DIVIDEND_W-1]};
      trial_sub = trial - {1'b0, div_ff};
      if (ctl.load) begin
         num_in = dividend;
         quo_in = '0;
         rem_in = '0;
         div_in = divisor;
         cnt_in = '0;
      end else if (ctl.step && (cnt_ff != DIV_CNT_W'(DIVIDEND_W))) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = trial_sub[SAMPLE_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in = trial[SAMPLE_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b0};
         end
         num_in = {num_ff[DIVIDEND_W-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      cnt_ff <= cnt_in;
   end

   assign quotient = quo_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/piezo_hit_detector_top.sv
// Top level of the piezo hit detector: sequencer, channel state and result register.
//
// One transaction on req_chan carries a sample of one piezo channel and the current
// millisecond time. Each accepted sample gives exactly one rsp_chan transaction:
// hit=1 with note = base_note + channel and velocity 1..127 when the strike fires,
// otherwise hit, note and velocity all zero. A strike needs the sample above
// hit_threshold, the channel not latched, and (now_ms - last hit time) mod 2^32
// above lockout_ms. A sample at or below the threshold releases the latch. Channels
// at or beyond NUM_CHANNELS are ignored (zero result, no state change).
// Timing: while rsp_chan drains, a sample goes through the accept step, the serial
// steps in which the 32-bit elapsed time is subtracted and compared with the lockout
// one bit per cycle, and the finish step that registers the result. The velocity
// divide (17 quotient bits, one per cycle) runs alongside and ends within the serial
// steps. The result sits in an output register; while it waits the next sample is
// still taken and runs its serial steps, and a stalled rsp_chan then holds the block
// in that sample's finish step so that further samples wait. Register writes on
// csr_chan are always taken (ready stays high) and must only be issued while the
// block is idle.
// No clearing pass after reset: per-channel state lives in flip-flops.
`default_nettype none
module piezo_hit_detector_top
   import pzhd_pkg::*;
#(
   parameter int NUM_CHANNELS = 4
)
(
   input  wire logic clock,
   input  wire logic reset,
   pzhd_req_if.sink   req_chan,
   pzhd_rsp_if.source rsp_chan,
   pzhd_csr_if.sink   csr_chan
);

   localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   // configuration registers
   logic [SAMPLE_W-1:0]  thr_ff,  thr_in;
   logic [LOCKOUT_W-1:0] lock_ff, lock_in;
   logic [BASE_W-1:0]    base_ff, base_in;

   // per-channel state
   logic [NUM_CHANNELS-1:0] latched_ff, latched_in;
   logic [TIME_W-1:0]       last_ff [NUM_CHANNELS];
   logic [TIME_W-1:0]       last_in [NUM_CHANNELS];

   // sequencer
   pzhd_state_type          state_ff, state_in;
   logic [STEP_CNT_W-1:0]   cnt_ff, cnt_in;

   // transaction held while the serial units run
   logic [CHAN_W-1:0]       chan_ff, chan_in;
   logic [CH_W-1:0]         idx_ff, idx_in;
   logic                    chan_ok_ff, chan_ok_in;
   logic                    above_ff, above_in;
   logic [TIME_W-1:0]       now_ff, now_in;

   // result register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_hit_ff, rsp_hit_in;
   logic [NOTE_W-1:0]       rsp_note_ff, rsp_note_in;
   logic [VEL_W-1:0]        rsp_vel_ff, rsp_vel_in;

   // control
   logic                    req_take;
   logic                    out_free;
   logic                    out_load;
   pzhd_ser_ctl_type        ser_ctl;

   // datapath
   logic [CH_W-1:0]         req_idx;
   logic                    req_ok;
   logic [SAMPLE_W-1:0]     excess;
   logic [DIVIDEND_W-1:0]   dividend;
   logic [SAMPLE_W-1:0]     span;
   logic [TIME_W-1:0]       last_rd;
   logic                    expired;
   logic [DIVIDEND_W-1:0]   quotient;
   logic                    fire;
   logic                    release_latch;
   logic [VEL_W-1:0]        vel;

   // ---------------------------------------------------------------- input side
   assign req_take = req_chan.valid && req_chan.ready;
   assign req_idx  = CH_W'(req_chan.channel);
   assign req_ok   = int'(req_chan.channel) < NUM_CHANNELS;
   assign last_rd  = req_ok ? last_ff[req_idx] : '0;

   // (s - t) * 126 as (x << 7) - (x << 1); only meaningful when s > t
   assign excess   = req_chan.sample - thr_ff;
   assign dividend = {excess, 7'b0} - {6'b0, excess, 1'b0};
   assign span     = ADC_FULL - thr_ff;

   assign csr_chan.ready = 1'b1;

   // ---------------------------------------------------------------- serial units
   pzhd_lockout_cmp u_lockout_cmp (
      .clock      (clock),
      .ctl        (ser_ctl),
      .now_ms     (req_chan.now_ms),
      .last_ms    (last_rd),
      .lockout_ms (lock_ff),
      .expired    (expired)
   );

   pzhd_vel_div u_vel_div (
      .clock    (clock),
      .ctl      (ser_ctl),
      .dividend (dividend),
      .divisor  (span),
      .quotient (quotient)
   );

   // ---------------------------------------------------------------- decision
   assign fire          = chan_ok_ff && above_ff && !latched_ff[idx_ff] && expired;
   assign release_latch = chan_ok_ff && !above_ff && latched_ff[idx_ff];

   // quotient stays at or below 126 on a hit; the clamp covers the rest
   always_comb begin
      if (quotient > VEL_TOP_Q) begin
         vel = VEL_MAX;
      end else begin
         vel = VEL_W'(quotient) + 1'b1;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (cnt_ff == STEP_CNT_W'(TIME_W - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_chan.ready = 1'b0;
      ser_ctl.load   = 1'b0;
      ser_ctl.step   = 1'b0;
      out_load       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            ser_ctl.load   = req_chan.valid;
         end
         ST_RUN: begin
            ser_ctl.step = 1'b1;
         end
         ST_FINISH: begin
            out_load = out_free;
         end
         default: begin
            req_chan.ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (req_take) begin
         cnt_in = '0;
      end else if (ser_ctl.step) begin
         cnt_in = cnt_ff + 1'b1;
      end
   end

   // ---------------------------------------------------------------- captured item
   always_comb begin
      chan_in    = chan_ff;
      idx_in     = idx_ff;
      chan_ok_in = chan_ok_ff;
      above_in   = above_ff;
      now_in     = now_ff;
      if (req_take) begin
         chan_in    = req_chan.channel;
         idx_in     = req_ok ? req_idx : '0;
         chan_ok_in = req_ok;
         above_in   = req_chan.sample > thr_ff;
         now_in     = req_chan.now_ms;
      end
   end

   // ---------------------------------------------------------------- channel state
   always_comb begin
      latched_in = latched_ff;
      last_in    = last_ff;
      if (out_load) begin
         if (fire) begin
            latched_in[idx_ff] = 1'b1;
            last_in[idx_ff]    = now_ff;
         end else if (release_latch) begin
            latched_in[idx_ff] = 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- configuration
   always_comb begin
      thr_in  = thr_ff;
      lock_in = lock_ff;
      base_in = base_ff;
      if (csr_chan.valid && csr_chan.ready) begin
         case (csr_chan.index)
            CSR_IDX_THRESHOLD: thr_in  = csr_chan.data[SAMPLE_W-1:0];
            CSR_IDX_LOCKOUT:   lock_in = csr_chan.data[LOCKOUT_W-1:0];
            CSR_IDX_BASE_NOTE: base_in = csr_chan.data[BASE_W-1:0];
            default:           thr_in  = thr_ff;
         endcase
      end
   end

   // ---------------------------------------------------------------- result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_note_in  = rsp_note_ff;
      rsp_vel_in   = rsp_vel_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_hit_in   = fire;
         rsp_note_in  = fire ? ({1'b0, base_ff} + {{(NOTE_W - CHAN_W){1'b0}}, chan_ff}) : '0;
         rsp_vel_in   = fire ? vel : '0;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.hit      = rsp_hit_ff;
   assign rsp_chan.note     = rsp_note_ff;
   assign rsp_chan.velocity = rsp_vel_ff;

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         thr_ff       <= THRESHOLD_RST;
         lock_ff      <= LOCKOUT_RST;
         base_ff      <= BASE_NOTE_RST;
         latched_ff   <= '0;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            last_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         thr_ff       <= thr_in;
         lock_ff      <= lock_in;
         base_ff      <= base_in;
         latched_ff   <= latched_in;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            last_ff[i] <= last_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      chan_ff     <= chan_in;
      idx_ff      <= idx_in;
      chan_ok_ff  <= chan_ok_in;
      above_ff    <= above_in;
      now_ff      <= now_in;
      rsp_hit_ff  <= rsp_hit_in;
      rsp_note_ff <= rsp_note_in;
      rsp_vel_ff  <= rsp_vel_in;
   end

   // ---------------------------------------------------------------- assertions
   a_take_starts_run: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == ST_RUN))
      else $error("accepted transaction did not start the serial run");

   a_result_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result raised outside the finish step");

   a_hit_has_velocity: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_hit_ff) |-> (rsp_vel_ff != '0))
      else $error("hit with zero velocity");

   a_miss_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_hit_ff) |-> ((rsp_vel_ff == '0) && (rsp_note_ff == '0)))
      else $error("non-hit result carries note or velocity");

endmodule
`default_nettype wire
